// ----- rtl/psd_pkg.sv -----
`timescale 1ns / 1ps
// Shared codes for the scaled decimal parser: result status, character codes
// and configuration register indexes. No dependencies.
package psd_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_NUM   = 3'd1,
    ST_MISS_FRAC = 3'd2,
    ST_TOO_MANY  = 3'd3,
    ST_BELOW_MIN = 3'd4,
    ST_ABOVE_MAX = 3'd5
  } status_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic [1:0] CFG_MIN_VALUE   = 2'd0;
  localparam logic [1:0] CFG_MAX_VALUE   = 2'd1;
  localparam logic [1:0] CFG_FRAC_DIGITS = 2'd2;
  localparam logic [1:0] CFG_FRAC_LIMIT  = 2'd3;

endpackage

// ----- rtl/parse_scaled_decimal.sv -----
`timescale 1ns / 1ps
// Decimal string to scaled fixed-point parser, top level.
// Depends on psd_pkg.
//
// Usage: characters enter one item at a time on char_in with in_valid/in_ready.
// A number is an optional '-', integer digits, an optional '.' and fraction
// digits. The first character that cannot extend the number ends it and one
// result item leaves on scaled_value/status/stop_char with out_valid/out_ready.
// Other characters produce no result.
// Sequence: an ordinary character is accepted, then makes one pass through the
// shared multiply-and-add unit before the next one is taken. An ending character
// runs S_EXEC, S_FIN, S_PAD (one zero-padding digit per step, up to frac_digits,
// through the same unit), S_CHK and S_EMIT, and then the next item is taken.
// Format errors skip padding and S_CHK; too many digits still passes S_FIN.
// Stall: the result sits in an output register; the parser keeps accepting
// characters meanwhile and only waits if a second result is ready to load.
// Reset: rst clears the parser to the idle phase, drops out_valid and loads
// the register defaults (full 32-bit range, 3 fraction digits, limit 5).
// Configuration: cfg_we writes cfg_data into register cfg_index at once.
module parse_scaled_decimal
  import psd_pkg::*;
#(
  parameter int ACC_BITS = 34
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] scaled_value,
  output logic [2:0]  status,
  output logic [7:0]  stop_char,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int VW = ACC_BITS + 1;
  localparam int SW = ACC_BITS + 4;
  localparam logic [ACC_BITS-1:0] ACC_TOP = '1;
  localparam logic signed [VW-1:0] I32_MAX = {{(VW-32){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [VW-1:0] I32_MIN = {{(VW-32){1'b1}}, 32'h8000_0000};

  typedef enum logic [2:0] {S_IN, S_EXEC, S_FIN, S_PAD, S_CHK, S_EMIT} seq_t;
  typedef enum logic [2:0] {P_IDLE, P_SIGN, P_INT, P_DOT, P_FRAC} phase_t;

  seq_t                state;
  phase_t              phase;
  logic                is_negative;
  logic [ACC_BITS-1:0] magnitude;
  logic [4:0]          frac_seen;
  logic [7:0]          ch;
  logic [3:0]          pad_cnt;
  logic [31:0]         res_value;
  status_t             res_status;

  logic [31:0] min_value;
  logic [31:0] max_value;
  logic [3:0]  frac_digits;
  logic [3:0]  frac_limit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_value   <= 32'h8000_0000;
      max_value   <= 32'h7FFF_FFFF;
      frac_digits <= 4'd3;
      frac_limit  <= 4'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_VALUE:   min_value   <= cfg_data;
        CFG_MAX_VALUE:   max_value   <= cfg_data;
        CFG_FRAC_DIGITS: frac_digits <= cfg_data[3:0];
        CFG_FRAC_LIMIT:  frac_limit  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // character decode
  logic       is_dig;
  logic [3:0] digit;
  logic [4:0] fd5;
  logic       keep_dig;
  logic       round_dig;

  always_comb begin
    is_dig    = (ch >= CH_ZERO) && (ch <= CH_NINE);
    digit     = 4'(ch - CH_ZERO);
    fd5       = {1'b0, frac_digits};
    keep_dig  = frac_seen < fd5;
    round_dig = (frac_seen == fd5) && (ch >= CH_FIVE);
  end

  // shared unit: magnitude * (10 or 1) + addend, saturating at the top
  logic          unit_mul;
  logic [3:0]    unit_add;
  logic [SW-1:0] unit_prod;
  logic [SW-1:0] unit_sum;
  logic [ACC_BITS-1:0] unit_res;

  always_comb begin
    unit_mul = 1'b1;
    unit_add = 4'd0;
    if (state == S_EXEC) begin
      if ((phase == P_DOT || phase == P_FRAC) && !keep_dig) begin
        unit_mul = 1'b0;
        unit_add = 4'd1;
      end else begin
        unit_add = digit;
      end
    end
    unit_prod = unit_mul ? (({4'b0, magnitude} << 3) + ({4'b0, magnitude} << 1))
                         : {4'b0, magnitude};
    unit_sum  = unit_prod + SW'(unit_add);
    unit_res  = (unit_sum > {4'b0, ACC_TOP}) ? ACC_TOP : unit_sum[ACC_BITS-1:0];
  end

  // range check on the signed value
  logic signed [VW-1:0] val;
  logic signed [VW-1:0] min_ext;
  logic signed [VW-1:0] max_ext;
  logic                 below;
  logic                 above;
  logic [31:0]          clamped;

  always_comb begin
    val     = is_negative ? -$signed({1'b0, magnitude}) : $signed({1'b0, magnitude});
    min_ext = {{(VW-32){min_value[31]}}, min_value};
    max_ext = {{(VW-32){max_value[31]}}, max_value};
    below   = val < min_ext;
    above   = val > max_ext;
    if (val > I32_MAX) begin
      clamped = 32'h7FFF_FFFF;
    end else if (val < I32_MIN) begin
      clamped = 32'h8000_0000;
    end else begin
      clamped = val[31:0];
    end
  end

  assign in_ready = (state == S_IN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IN;
      phase       <= P_IDLE;
      is_negative <= 1'b0;
      magnitude   <= '0;
      frac_seen   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == S_EMIT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IN: begin
          if (in_valid) begin
            ch    <= char_in;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IN;
          unique case (phase)
            P_IDLE, P_SIGN: begin
              if (phase == P_IDLE && ch == CH_MINUS) begin
                is_negative <= 1'b1;
                phase       <= P_SIGN;
              end else if (is_dig) begin
                magnitude <= unit_res;
                phase     <= P_INT;
              end else if (ch == CH_DOT) begin
                phase <= P_DOT;
              end else begin
                res_value  <= '0;
                res_status <= ST_NOT_NUM;
                state      <= S_EMIT;
              end
            end
            P_INT: begin
              if (is_dig) begin
                magnitude <= unit_res;
              end else if (ch == CH_DOT) begin
                phase <= P_DOT;
              end else begin
                state <= S_FIN;
              end
            end
            P_DOT, P_FRAC: begin
              if (!is_dig) begin
                if (phase == P_DOT) begin
                  res_value  <= '0;
                  res_status <= ST_MISS_FRAC;
                  state      <= S_EMIT;
                end else begin
                  state <= S_FIN;
                end
              end else begin
                phase <= P_FRAC;
                if (keep_dig || round_dig) begin
                  magnitude <= unit_res;
                end
                if (frac_seen != 5'd31) begin
                  frac_seen <= frac_seen + 5'd1;
                end
              end
            end
            default: begin
              phase       <= P_IDLE;
              is_negative <= 1'b0;
              magnitude   <= '0;
              frac_seen   <= '0;
            end
          endcase
        end
        S_FIN: begin
          if (frac_seen > {1'b0, frac_limit}) begin
            res_value  <= '0;
            res_status <= ST_TOO_MANY;
            state      <= S_EMIT;
          end else begin
            pad_cnt <= keep_dig ? 4'(fd5 - frac_seen) : 4'd0;
            state   <= S_PAD;
          end
        end
        S_PAD: begin
          // append one zero digit per cycle
          if (pad_cnt != 4'd0) begin
            magnitude <= unit_res;
            pad_cnt   <= pad_cnt - 4'd1;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          res_value <= clamped;
          priority if (below) begin
            res_status <= ST_BELOW_MIN;
          end else if (above) begin
            res_status <= ST_ABOVE_MAX;
          end else begin
            res_status <= ST_OK;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            scaled_value <= res_value;
            status       <= res_status;
            stop_char    <= ch;
            phase        <= P_IDLE;
            is_negative  <= 1'b0;
            magnitude    <= '0;
            frac_seen    <= '0;
            state        <= S_IN;
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

  a_fmt_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NOT_NUM || status == ST_MISS_FRAC || status == ST_TOO_MANY)
    |-> scaled_value == 32'd0)
    else $error("format error result carries a nonzero value");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == P_IDLE |-> magnitude == '0 && !is_negative && frac_seen == 5'd0)
    else $error("idle phase with leftover parse state");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_EXEC && !in_ready)
    else $error("accepted item not executed next cycle");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> phase == P_IDLE && state == S_IN)
    else $error("result emitted without clearing the parser");

endmodule
